@@ design/bmrf_pkg.sv @@
// Shared types and constants for the broadcast multi-reader FIFO.
// Holds command/status codes, sequencer states and the item/result structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bmrf_pkg;

    // Sizing
    localparam int NUM_PORTS  = 4;
    localparam int FIFO_DEPTH = 64;
    localparam int PORT_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = PORT_W + PTR_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;

    // Fixed field widths
    localparam int PORT_FIELD_W = 2;
    localparam int DATA_W       = 8;
    localparam int FILL_W       = 7;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_CLOSED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_PUSH,
        S_RDWAIT,
        S_REPORT
    } state_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [PORT_FIELD_W-1:0] port;
        logic                    write_only;
        logic [DATA_W-1:0]       data;
        logic                    last_of_burst;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data_out;
        logic [FILL_W-1:0] fill_level;
        logic              burst_end;
    } result_t;

    // Byte store access request
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

endpackage

@@ design/bmrf_store.sv @@
// Byte store shared by all port ring buffers: one access per cycle.
// Registered read data. Depends on bmrf_pkg.
`timescale 1ns / 1ps

module bmrf_store
    import bmrf_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/broadcast_multi_reader_fifo.sv @@
// Open, close, an empty read and any command on a closed port end in S_EXEC; a read that
// pops a byte waits in S_RDWAIT for store data. A write checks each port for a full
// buffer in S_CHECK and, if none is full, pushes to the open ports in S_PUSH, one port per
// cycle in each, then reports in S_REPORT. busy is low in the strobe cycle, so the next
// transfer can start there; no new item is taken while busy; the receiver cannot stall.
// rst_n closes all ports and clears pointers and counts; the byte store is not cleared.
`timescale 1ns / 1ps

module broadcast_multi_reader_fifo
    import bmrf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [PORT_W-1:0] idx_reg, idx_next;
    logic              full_reg, full_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [PTR_W-1:0] wr_ptr_reg [NUM_PORTS];
    logic [PTR_W-1:0] wr_ptr_next[NUM_PORTS];
    logic [PTR_W-1:0] rd_ptr_reg [NUM_PORTS];
    logic [PTR_W-1:0] rd_ptr_next[NUM_PORTS];
    logic [CNT_W-1:0] count_reg  [NUM_PORTS];
    logic [CNT_W-1:0] count_next [NUM_PORTS];
    logic [NUM_PORTS-1:0] active_reg, active_next;
    logic [NUM_PORTS-1:0] wo_reg, wo_next;

    logic [PORT_W-1:0] port_idx;
    logic              port_ok;
    logic [PORT_W-1:0] sel_port;
    logic              last_idx;
    logic              sel_full;
    logic [CNT_W-1:0]  sel_count;
    logic [PTR_W-1:0]  sel_wr_ptr;
    logic [PTR_W-1:0]  sel_rd_ptr;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    bmrf_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Addressed port and the one port looked at this cycle
    assign port_idx   = PORT_W'(item_reg.port);
    assign port_ok    = 32'(item_reg.port) < NUM_PORTS;
    assign sel_port   = (state_reg == S_CHECK || state_reg == S_PUSH) ? idx_reg : port_idx;
    assign last_idx   = (idx_reg == PORT_W'(NUM_PORTS - 1));
    assign sel_count  = count_reg[sel_port];
    assign sel_wr_ptr = wr_ptr_reg[sel_port];
    assign sel_rd_ptr = rd_ptr_reg[sel_port];
    assign sel_full   = active_reg[sel_port] && (sel_count >= CNT_W'(FIFO_DEPTH));

    // Control, command and per-port state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            item_reg   <= '0;
            idx_reg    <= '0;
            full_reg   <= 1'b0;
            done_reg   <= 1'b0;
            active_reg <= '0;
            wo_reg     <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            idx_reg    <= idx_next;
            full_reg   <= full_next;
            done_reg   <= done_next;
            active_reg <= active_next;
            wo_reg     <= wo_next;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                wr_ptr_reg[i] <= wr_ptr_next[i];
                rd_ptr_reg[i] <= rd_ptr_next[i];
                count_reg[i]  <= count_next[i];
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Sequencer: next state, per-port updates and byte store requests
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        full_next   = full_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        active_next = active_reg;
        wo_next     = wo_reg;
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            wr_ptr_next[i] = wr_ptr_reg[i];
            rd_ptr_next[i] = rd_ptr_reg[i];
            count_next[i]  = count_reg[i];
        end
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = {sel_port, sel_wr_ptr};
        mem_req.wdata = item_reg.data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                result_next.status     = ST_OK;
                result_next.data_out   = '0;
                result_next.fill_level = '0;
                result_next.burst_end  = item_reg.last_of_burst;
                idx_next               = '0;
                full_next              = 1'b0;
                if (!port_ok)
                begin
                    result_next.status = ST_CLOSED;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (item_reg.cmd == CMD_OPEN)
                begin
                    wr_ptr_next[sel_port] = '0;
                    rd_ptr_next[sel_port] = '0;
                    count_next[sel_port]  = '0;
                    active_next[sel_port] = 1'b1;
                    wo_next[sel_port]     = item_reg.write_only;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (!active_reg[sel_port])
                begin
                    result_next.status = ST_CLOSED;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    unique case (item_reg.cmd)
                        CMD_CLOSE:
                        begin
                            active_next[sel_port]  = 1'b0;
                            result_next.fill_level = FILL_W'(sel_count);
                            done_next              = 1'b1;
                            state_next             = S_IDLE;
                        end
                        CMD_WRITE:
                        begin
                            state_next = S_CHECK;
                        end
                        CMD_READ:
                        begin
                            if (sel_count == '0)
                            begin
                                result_next.status = ST_EMPTY;
                                done_next          = 1'b1;
                                state_next         = S_IDLE;
                            end
                            else
                            begin
                                mem_req.re             = 1'b1;
                                mem_req.addr           = {sel_port, sel_rd_ptr};
                                rd_ptr_next[sel_port]  = ptr_inc(sel_rd_ptr);
                                count_next[sel_port]   = sel_count - 1'b1;
                                result_next.fill_level = FILL_W'(sel_count - 1'b1);
                                state_next             = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // One port per cycle: is any open buffer full?
            S_CHECK:
            begin
                full_next = full_reg | sel_full;
                idx_next  = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = (full_reg | sel_full) ? S_REPORT : S_PUSH;
                end
            end

            // One port per cycle: push the byte into each open buffer, skipping the addressed port if write-only
            S_PUSH:
            begin
                if (active_reg[sel_port] && !(sel_port == port_idx && wo_reg[sel_port]))
                begin
                    mem_req.we            = 1'b1;
                    wr_ptr_next[sel_port] = ptr_inc(sel_wr_ptr);
                    count_next[sel_port]  = sel_count + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_REPORT;
                end
            end

            S_RDWAIT:
            begin
                result_next.data_out = mem_rdata;
                done_next            = 1'b1;
                state_next           = S_IDLE;
            end

            S_REPORT:
            begin
                result_next.status     = full_reg ? ST_FULL : ST_OK;
                result_next.fill_level = FILL_W'(sel_count);
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The result strobe only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");

    // A transfer always leaves idle
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == S_EXEC)
        else $error("accepted transfer did not start");

    // A push never lands in a full buffer
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && active_reg[sel_port]) |-> sel_count < CNT_W'(FIFO_DEPTH))
        else $error("push into a full buffer");

    // Counts stay within the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sel_count <= CNT_W'(FIFO_DEPTH))
        else $error("fill count beyond depth");

    // An empty read reports nothing held and no data
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_EMPTY) |->
            (result_reg.fill_level == '0 && result_reg.data_out == '0))
        else $error("empty read with data or fill");

endmodule
